[rtl/etg_pkg.sv]
// Shared types, constants and palette ROM for the escape-time gradient colorizer.
// No dependencies; every other file of the block refers to it by scoped names.
package etg_pkg;

    localparam int NUM_PALETTES_DEF  = 9;
    localparam int MAX_STOPS_DEF     = 9;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int ROM_PALETTES = 9;
    localparam int ROM_STOPS    = 9;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ITER_MAX = 2'd0,
        REG_REPEAT   = 2'd1,
        REG_PALETTE  = 2'd2
    } cfg_reg_t;

    // pipeline control handed to each stage group
    typedef struct packed {
        logic adv;
        logic valid;
    } pipe_ctrl_t;

    // one gradient stop, position in Q1.16 (1.0 = 65536)
    typedef struct packed {
        logic [16:0] pos;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } stop_t;

    function automatic stop_t mk(input logic [16:0] pos, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b);
        stop_t s;
        s.pos = pos;
        s.r   = r;
        s.g   = g;
        s.b   = b;
        return s;
    endfunction

    // number of stops stored for each palette
    function automatic logic [3:0] rom_count(input logic [3:0] pal);
        logic [3:0] c;
        case (pal)
            4'd4:    c = 4'd7;
            4'd5:    c = 4'd5;
            4'd8:    c = 4'd9;
            default: c = 4'd4;
        endcase
        return c;
    endfunction

    // palette ROM: fire, ocean, forest, violet, rainbow, sunset, plasma, ice, cosmic
    function automatic stop_t rom_stop(input logic [3:0] pal, input logic [3:0] idx);
        stop_t s;
        s = mk(17'd0, 8'd0, 8'd0, 8'd0);
        case (pal)
            4'd0: begin
                case (idx)
                    4'd1:    s = mk(17'd21627, 8'd255, 8'd0, 8'd0);
                    4'd2:    s = mk(17'd43254, 8'd255, 8'd255, 8'd0);
                    4'd3:    s = mk(17'd65536, 8'd255, 8'd255, 8'd255);
                    default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
                endcase
            end
            4'd1: begin
                case (idx)
                    4'd1:    s = mk(17'd21627, 8'd0, 8'd0, 8'd255);
                    4'd2:    s = mk(17'd43254, 8'd0, 8'd255, 8'd255);
                    4'd3:    s = mk(17'd65536, 8'd255, 8'd255, 8'd255);
                    default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
                endcase
            end
            4'd2: begin
                case (idx)
                    4'd1:    s = mk(17'd21627, 8'd0, 8'd180, 8'd0);
                    4'd2:    s = mk(17'd43254, 8'd200, 8'd255, 8'd0);
                    4'd3:    s = mk(17'd65536, 8'd255, 8'd255, 8'd255);
                    default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
                endcase
            end
            4'd3: begin
                case (idx)
                    4'd1:    s = mk(17'd21627, 8'd128, 8'd0, 8'd200);
                    4'd2:    s = mk(17'd43254, 8'd255, 8'd100, 8'd255);
                    4'd3:    s = mk(17'd65536, 8'd255, 8'd255, 8'd255);
                    default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
                endcase
            end
            4'd4: begin
                case (idx)
                    4'd0:    s = mk(17'd0, 8'd255, 8'd0, 8'd0);
                    4'd1:    s = mk(17'd10879, 8'd255, 8'd165, 8'd0);
                    4'd2:    s = mk(17'd21823, 8'd255, 8'd255, 8'd0);
                    4'd3:    s = mk(17'd32768, 8'd0, 8'd255, 8'd0);
                    4'd4:    s = mk(17'd43647, 8'd0, 8'd255, 8'd255);
                    4'd5:    s = mk(17'd54591, 8'd0, 8'd0, 8'd255);
                    4'd6:    s = mk(17'd65536, 8'd180, 8'd0, 8'd255);
                    default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
                endcase
            end
            4'd5: begin
                case (idx)
                    4'd1:    s = mk(17'd16384, 8'd255, 8'd140, 8'd0);
                    4'd2:    s = mk(17'd32768, 8'd255, 8'd0, 8'd0);
                    4'd3:    s = mk(17'd49152, 8'd255, 8'd0, 8'd200);
                    4'd4:    s = mk(17'd65536, 8'd55, 8'd0, 8'd255);
                    default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
                endcase
            end
            4'd6: begin
                case (idx)
                    4'd0:    s = mk(17'd0, 8'd13, 8'd8, 8'd135);
                    4'd1:    s = mk(17'd21627, 8'd126, 8'd3, 8'd168);
                    4'd2:    s = mk(17'd43254, 8'd240, 8'd87, 8'd100);
                    4'd3:    s = mk(17'd65536, 8'd240, 8'd230, 8'd50);
                    default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
                endcase
            end
            4'd7: begin
                case (idx)
                    4'd0:    s = mk(17'd0, 8'd255, 8'd255, 8'd255);
                    4'd1:    s = mk(17'd21627, 8'd150, 8'd230, 8'd255);
                    4'd2:    s = mk(17'd43254, 8'd30, 8'd90, 8'd200);
                    4'd3:    s = mk(17'd65536, 8'd5, 8'd10, 8'd30);
                    default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
                endcase
            end
            4'd8: begin
                case (idx)
                    4'd1:    s = mk(17'd9372, 8'd0, 8'd0, 8'd51);
                    4'd2:    s = mk(17'd18743, 8'd0, 8'd77, 8'd64);
                    4'd3:    s = mk(17'd28115, 8'd64, 8'd224, 8'd208);
                    4'd4:    s = mk(17'd37421, 8'd200, 8'd220, 8'd240);
                    4'd5:    s = mk(17'd46793, 8'd255, 8'd255, 8'd224);
                    4'd6:    s = mk(17'd56164, 8'd255, 8'd215, 8'd0);
                    4'd7:    s = mk(17'd60883, 8'd255, 8'd165, 8'd0);
                    4'd8:    s = mk(17'd65536, 8'd139, 8'd0, 8'd0);
                    default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
                endcase
            end
            default: s = mk(17'd0, 8'd0, 8'd0, 8'd0);
        endcase
        return s;
    endfunction

    // rescale a Q1.16 stop position to Q1.fb; caller keeps the low fb+1 bits
    function automatic logic [40:0] scale_pos(input logic [16:0] pos, input int fb);
        logic [40:0] w;
        w = 41'(pos) << fb;
        return w >> 16;
    endfunction

endpackage

[rtl/escape_time_gradient_colorizer.sv]
// Top level of the escape-time gradient colorizer: normalize, repeat, mirror, blend.
// Depends on etg_pkg, etg_norm_div and etg_chan_div.
// Throughput: one pixel per clock; the whole pipeline advances together and holds on stall.
// Depth is set by the normalizing divider (one bit per stage) and the 8-stage channel divider.
// Reset: synchronous active-low aresetn clears all valid bits and loads iter_max 256,
// repeat_count 1, palette_select 0.
module escape_time_gradient_colorizer #(
    parameter int NUM_PALETTE_TABLES = etg_pkg::NUM_PALETTES_DEF,
    parameter int MAX_STOPS          = etg_pkg::MAX_STOPS_DEF,
    parameter int FRACTION_BITS      = etg_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] iter_count, [31:16] smooth_adjust
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int FB = FRACTION_BITS;
    localparam int UW = FB + 1;
    localparam int XW = FB + 9;
    localparam logic [UW-1:0] U_ONE = UW'(1) << FB;

    // configuration registers
    logic [15:0] iter_max_reg;
    logic [7:0]  repeat_reg;
    logic [3:0]  palette_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_max_reg <= 16'd256;
            repeat_reg   <= 8'd1;
            palette_reg  <= 4'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                etg_pkg::REG_ITER_MAX: iter_max_reg <= cfg_wdata;
                etg_pkg::REG_REPEAT:   repeat_reg   <= cfg_wdata[7:0];
                etg_pkg::REG_PALETTE:  palette_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances when the output slot is free or being taken
    logic                adv;
    logic                m_tvalid_reg;
    logic [23:0]         m_tdata_reg;
    etg_pkg::pipe_ctrl_t ctrl_in;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // palette selection and usable stop count, from the live registers
    logic [3:0] sel;
    logic [3:0] rom_n;
    logic [4:0] n_stops;
    logic [3:0] last_idx;

    always_comb begin
        if (32'(palette_reg) >= NUM_PALETTE_TABLES || 32'(palette_reg) >= etg_pkg::ROM_PALETTES)
        begin
            sel = 4'd0;
        end else begin
            sel = palette_reg;
        end
        rom_n = etg_pkg::rom_count(sel);
        if (32'(rom_n) > MAX_STOPS) begin
            n_stops = 5'(MAX_STOPS);
        end else begin
            n_stops = {1'b0, rom_n};
        end
        if (n_stops < 5'd2) begin
            n_stops = 5'd2;
        end
        last_idx = 4'(n_stops - 5'd1);
    end

    // form the smoothed count, flag inside-set and saturation
    logic [15:0]        in_cnt;
    logic signed [15:0] in_adj;
    logic signed [25:0] s_sum;
    logic [24:0]        s_clamp;
    logic [23:0]        den;
    logic               in_blk;
    logic               in_sat;

    assign in_cnt  = s_tdata[15:0];
    assign in_adj  = $signed(s_tdata[31:16]);
    assign s_sum   = $signed({2'b00, in_cnt, 8'h00}) + {{10{in_adj[15]}}, in_adj};
    assign s_clamp = s_sum[25] ? 25'd0 : s_sum[24:0];
    assign den     = {iter_max_reg, 8'h00};
    assign in_blk  = in_cnt >= iter_max_reg;
    assign in_sat  = s_clamp >= {1'b0, den};

    assign ctrl_in.adv   = adv;
    assign ctrl_in.valid = s_tvalid;

    logic          dv_valid;
    logic [FB-1:0] dv_q;
    logic [1:0]    dv_flag;

    etg_norm_div #(.FB(FB)) u_norm_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_in   (ctrl_in),
        .rem_in    (s_clamp),
        .den_in    (den),
        .flag_in   ({in_blk, in_sat}),
        .valid_out (dv_valid),
        .q_out     (dv_q),
        .flag_out  (dv_flag)
    );

    // stage 1: saturate t and scale by the repeat count
    logic [FB-1:0] t_sat;
    logic          v1_reg;
    logic [FB+7:0] p1_reg;
    logic          tnz1_reg;
    logic          blk1_reg;

    assign t_sat = dv_flag[0] ? '1 : dv_q;

    // stage 2: split cycle and fraction, fix the boundary, mirror odd cycles
    logic [7:0]    cyc;
    logic [FB-1:0] frac;
    logic [UW-1:0] u_next;
    logic          v2_reg;
    logic [UW-1:0] u2_reg;
    logic          blk2_reg;

    always_comb begin
        cyc  = p1_reg[FB+7:FB];
        frac = p1_reg[FB-1:0];
        if (frac == '0 && tnz1_reg) begin
            frac = '1;
            if (cyc != 8'd0) begin
                cyc = cyc - 8'd1;
            end
        end
        if (cyc[0]) begin
            u_next = U_ONE - {1'b0, frac};
        end else begin
            u_next = {1'b0, frac};
        end
    end

    // stage 3: compare u against every stop position
    logic [etg_pkg::ROM_STOPS-1:0] ge_next;
    logic [UW-1:0]                 pos_first;
    logic [UW-1:0]                 pos_last;
    logic                          v3_reg;
    logic [etg_pkg::ROM_STOPS-1:0] ge3_reg;
    logic                          lef3_reg;
    logic                          gel3_reg;
    logic [UW-1:0]                 u3_reg;
    logic                          blk3_reg;

    always_comb begin
        for (int i = 0; i < etg_pkg::ROM_STOPS; i++) begin
            ge_next[i] = u2_reg >= UW'(etg_pkg::scale_pos(etg_pkg::rom_stop(sel, 4'(i)).pos, FB));
        end
        pos_first = UW'(etg_pkg::scale_pos(etg_pkg::rom_stop(sel, 4'd0).pos, FB));
        pos_last  = UW'(etg_pkg::scale_pos(etg_pkg::rom_stop(sel, last_idx).pos, FB));
    end

    // stage 4: pick the segment and set up the blend terms
    logic [3:0]          seg;
    etg_pkg::stop_t      st_a;
    etg_pkg::stop_t      st_b;
    logic [UW-1:0]       lo;
    logic [UW-1:0]       hi;
    logic [2:0][7:0]     a_c;
    logic [2:0][7:0]     b_c;
    logic [2:0][8:0]     d_next;
    logic [UW-1:0]       off_next;
    logic [UW-1:0]       span_next;
    logic                v4_reg;
    logic [2:0][7:0]     a4_reg;
    logic [2:0][8:0]     d4_reg;
    logic [UW-1:0]       off4_reg;
    logic [UW-1:0]       span4_reg;
    logic                blk4_reg;

    always_comb begin
        seg = 4'd0;
        for (int i = 1; i < etg_pkg::ROM_STOPS; i++) begin
            if (5'(i) < n_stops && ge3_reg[i]) begin
                seg = seg + 4'd1;
            end
        end
        if (lef3_reg) begin
            st_a = etg_pkg::rom_stop(sel, 4'd0);
        end else if (gel3_reg) begin
            st_a = etg_pkg::rom_stop(sel, last_idx);
        end else begin
            st_a = etg_pkg::rom_stop(sel, seg);
        end
        st_b = etg_pkg::rom_stop(sel, seg + 4'd1);
        lo   = UW'(etg_pkg::scale_pos(st_a.pos, FB));
        hi   = UW'(etg_pkg::scale_pos(st_b.pos, FB));
        a_c  = {st_a.b, st_a.g, st_a.r};
        b_c  = {st_b.b, st_b.g, st_b.r};
        if (lef3_reg || gel3_reg || hi <= lo) begin
            d_next    = '0;
            off_next  = '0;
            span_next = UW'(1);
        end else begin
            for (int c = 0; c < 3; c++) begin
                d_next[c] = {1'b0, b_c[c]} - {1'b0, a_c[c]};
            end
            off_next  = u3_reg - lo;
            span_next = hi - lo;
        end
    end

    // stage 5: scale the channel deltas by the offset
    logic [2:0][7:0]    mag;
    logic               v5_reg;
    logic [2:0][XW-1:0] x5_reg;
    logic [2:0]         neg5_reg;
    logic [2:0][7:0]    a5_reg;
    logic [UW-1:0]      span5_reg;
    logic               blk5_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mag[c] = d4_reg[c][8] ? 8'(-d4_reg[c]) : d4_reg[c][7:0];
        end
    end

    // pipeline registers, valid bits under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= dv_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg    <= (FB+8)'(t_sat) * (FB+8)'(repeat_reg);
            tnz1_reg  <= t_sat != '0;
            blk1_reg  <= dv_flag[1];
            u2_reg    <= u_next;
            blk2_reg  <= blk1_reg;
            ge3_reg   <= ge_next;
            lef3_reg  <= u2_reg <= pos_first;
            gel3_reg  <= u2_reg >= pos_last;
            u3_reg    <= u2_reg;
            blk3_reg  <= blk2_reg;
            a4_reg    <= a_c;
            d4_reg    <= d_next;
            off4_reg  <= off_next;
            span4_reg <= span_next;
            blk4_reg  <= blk3_reg;
            for (int c = 0; c < 3; c++) begin
                x5_reg[c]   <= XW'(mag[c]) * XW'(off4_reg);
                neg5_reg[c] <= d4_reg[c][8];
            end
            a5_reg    <= a4_reg;
            span5_reg <= span4_reg;
            blk5_reg  <= blk4_reg;
        end
    end

    etg_pkg::pipe_ctrl_t ctrl_cd;
    logic                cd_valid;
    logic [2:0][7:0]     cd_q;
    logic [2:0]          cd_rnz;
    logic [2:0][7:0]     cd_a;
    logic [2:0]          cd_neg;
    logic                cd_blk;

    assign ctrl_cd.adv   = adv;
    assign ctrl_cd.valid = v5_reg;

    etg_chan_div #(.FB(FB)) u_chan_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_in   (ctrl_cd),
        .x_in      (x5_reg),
        .span_in   (span5_reg),
        .a_in      (a5_reg),
        .neg_in    (neg5_reg),
        .blk_in    (blk5_reg),
        .valid_out (cd_valid),
        .q_out     (cd_q),
        .rnz_out   (cd_rnz),
        .a_out     (cd_a),
        .neg_out   (cd_neg),
        .blk_out   (cd_blk)
    );

    // output stage: floor the blend, clamp, force black inside the set
    logic signed [9:0] chan_v [3];
    logic [23:0]       rgb_next;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (cd_neg[c]) begin
                chan_v[c] = $signed({2'b00, cd_a[c]}) - $signed({2'b00, cd_q[c]})
                            - $signed({9'd0, cd_rnz[c]});
            end else begin
                chan_v[c] = $signed({2'b00, cd_a[c]}) + $signed({2'b00, cd_q[c]});
            end
            if (cd_blk || chan_v[c] < 0) begin
                rgb_next[c*8 +: 8] = 8'd0;
            end else if (chan_v[c] > 10'sd255) begin
                rgb_next[c*8 +: 8] = 8'd255;
            end else begin
                rgb_next[c*8 +: 8] = chan_v[c][7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= cd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= rgb_next;
        end
    end

    // mirrored position never passes one
    a_u_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> u2_reg <= U_ONE)
        else $error("gradient position above one");

    // interior lookups land on a real segment
    a_seg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !lef3_reg && !gel3_reg) |-> (5'(seg) + 5'd1 < n_stops))
        else $error("segment index past last stop");

    // a zero position scales to a zero product
    a_zero_t: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !tnz1_reg) |-> p1_reg == '0)
        else $error("nonzero product from zero position");

endmodule

[rtl/etg_norm_div.sv]
// Pipelined restoring divider: fraction bits of rem/den, one quotient bit per stage.
// Depends on etg_pkg for the pipeline control struct.
module etg_norm_div #(
    parameter int FB = etg_pkg::FRACTION_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  etg_pkg::pipe_ctrl_t ctrl_in,
    input  logic [24:0]         rem_in,
    input  logic [23:0]         den_in,
    input  logic [1:0]          flag_in,
    output logic                valid_out,
    output logic [FB-1:0]       q_out,
    output logic [1:0]          flag_out
);

    logic [FB-1:0] v_reg;
    logic [24:0]   r_reg [FB];
    logic [23:0]   d_reg [FB];
    logic [FB-1:0] q_reg [FB];
    logic [1:0]    f_reg [FB];

    genvar k;
    generate
        for (k = 0; k < FB; k++) begin : g_stage
            logic          v_prev;
            logic [24:0]   r_prev;
            logic [23:0]   d_prev;
            logic [FB-1:0] q_prev;
            logic [1:0]    f_prev;
            logic [25:0]   r_dbl;
            logic [25:0]   r_sub;
            logic          take;

            if (k == 0) begin : g_first
                assign v_prev = ctrl_in.valid;
                assign r_prev = rem_in;
                assign d_prev = den_in;
                assign q_prev = '0;
                assign f_prev = flag_in;
            end else begin : g_next
                assign v_prev = v_reg[k-1];
                assign r_prev = r_reg[k-1];
                assign d_prev = d_reg[k-1];
                assign q_prev = q_reg[k-1];
                assign f_prev = f_reg[k-1];
            end

            // shift in one bit and subtract when the divisor fits
            assign r_dbl = {r_prev, 1'b0};
            assign take  = r_dbl >= {2'b00, d_prev};
            assign r_sub = r_dbl - {2'b00, d_prev};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (ctrl_in.adv) begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (ctrl_in.adv) begin
                    r_reg[k] <= take ? r_sub[24:0] : r_dbl[24:0];
                    d_reg[k] <= d_prev;
                    q_reg[k] <= {q_prev[FB-2:0], take};
                    f_reg[k] <= f_prev;
                end
            end
        end
    endgenerate

    assign valid_out = v_reg[FB-1];
    assign q_out     = q_reg[FB-1];
    assign flag_out  = f_reg[FB-1];

endmodule

[rtl/etg_chan_div.sv]
// Pipelined 8-bit quotient divider for the three color channels of the blend.
// Depends on etg_pkg for the pipeline control struct.
module etg_chan_div #(
    parameter int FB = etg_pkg::FRACTION_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  etg_pkg::pipe_ctrl_t ctrl_in,
    input  logic [2:0][FB+8:0]  x_in,
    input  logic [FB:0]         span_in,
    input  logic [2:0][7:0]     a_in,
    input  logic [2:0]          neg_in,
    input  logic                blk_in,
    output logic                valid_out,
    output logic [2:0][7:0]     q_out,
    output logic [2:0]          rnz_out,
    output logic [2:0][7:0]     a_out,
    output logic [2:0]          neg_out,
    output logic                blk_out
);

    localparam int XW = FB + 9;

    logic [7:0]         v_reg;
    logic [2:0][XW-1:0] r_reg [8];
    logic [2:0][7:0]    q_reg [8];
    logic [FB:0]        s_reg [8];
    logic [2:0][7:0]    a_reg [8];
    logic [2:0]         n_reg [8];
    logic [7:0]         b_reg;

    genvar k, c;
    generate
        for (k = 0; k < 8; k++) begin : g_stage
            logic               v_prev;
            logic [2:0][XW-1:0] r_prev;
            logic [2:0][7:0]    q_prev;
            logic [FB:0]        s_prev;
            logic [2:0][7:0]    a_prev;
            logic [2:0]         n_prev;
            logic               b_prev;
            logic [XW-1:0]      dsh;
            logic [2:0][XW-1:0] r_nxt;
            logic [2:0][7:0]    q_nxt;

            if (k == 0) begin : g_first
                assign v_prev = ctrl_in.valid;
                assign r_prev = x_in;
                assign q_prev = '0;
                assign s_prev = span_in;
                assign a_prev = a_in;
                assign n_prev = neg_in;
                assign b_prev = blk_in;
            end else begin : g_next
                assign v_prev = v_reg[k-1];
                assign r_prev = r_reg[k-1];
                assign q_prev = q_reg[k-1];
                assign s_prev = s_reg[k-1];
                assign a_prev = a_reg[k-1];
                assign n_prev = n_reg[k-1];
                assign b_prev = b_reg[k-1];
            end

            // divisor aligned to quotient bit 7-k
            assign dsh = XW'(s_prev) << (7 - k);

            for (c = 0; c < 3; c++) begin : g_chan
                logic take;
                assign take     = r_prev[c] >= dsh;
                assign r_nxt[c] = take ? r_prev[c] - dsh : r_prev[c];
                assign q_nxt[c] = {q_prev[c][6:0], take};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (ctrl_in.adv) begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (ctrl_in.adv) begin
                    r_reg[k] <= r_nxt;
                    q_reg[k] <= q_nxt;
                    s_reg[k] <= s_prev;
                    a_reg[k] <= a_prev;
                    n_reg[k] <= n_prev;
                    b_reg[k] <= b_prev;
                end
            end
        end
    endgenerate

    assign valid_out = v_reg[7];
    assign q_out     = q_reg[7];
    assign a_out     = a_reg[7];
    assign neg_out   = n_reg[7];
    assign blk_out   = b_reg[7];

    generate
        for (c = 0; c < 3; c++) begin : g_rnz
            assign rnz_out[c] = r_reg[7][c] != '0;
        end
    endgenerate

endmodule
